// ===== sv/lcdn_pkg.sv =====
package lcdn_pkg;

  localparam int unsigned MaxDigitsDef = 16;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned ValueWidth   = 16;
  localparam int unsigned BcdDigits    = 5;
  localparam int unsigned HexDigits    = ValueWidth / 4;
  localparam int unsigned DigitsWidth  = 4 * BcdDigits;

  localparam logic [2:0] CMD_CHAR = 3'd0;
  localparam logic [2:0] CMD_UDEC = 3'd1;
  localparam logic [2:0] CMD_SDEC = 3'd2;
  localparam logic [2:0] CMD_HEX  = 3'd3;
  localparam logic [2:0] CMD_BIN  = 3'd4;

  localparam logic [1:0] LINE_ONE = 2'd1;
  localparam logic [1:0] LINE_TWO = 2'd2;

  localparam logic [7:0] SET_CURSOR    = 8'h80;
  localparam logic [7:0] LINE_TWO_BASE = 8'h40;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_A        = 8'h41;
  localparam logic [7:0] CHAR_MINUS    = 8'h2D;
  localparam logic [7:0] CHAR_PLUS     = 8'h2B;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_HEX,
    RADIX_BIN
  } radix_e;

  typedef struct packed {
    logic                   has_cursor;
    logic [7:0]             cursor_byte;
    logic                   has_lead;
    logic [7:0]             lead_byte;
    logic [4:0]             count;
    radix_e                 radix;
    logic [DigitsWidth-1:0] digits;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'b0000, d};
    end else begin
      c = CHAR_A + {4'b0000, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== sv/lcdn_if.sv =====
interface lcdn_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [1:0]  line;
  logic [4:0]  column;
  logic [7:0]  character;
  logic [15:0] value;
  logic [4:0]  digit_count;

  modport source (output valid, command, line, column, character, value, digit_count,
                  input ready);
  modport sink (input valid, command, line, column, character, value, digit_count,
                output ready);
endinterface

interface lcdn_wr_if;
  logic       valid;
  logic       ready;
  logic       is_data;
  logic [7:0] bus_byte;
  logic       last;

  modport source (output valid, is_data, bus_byte, last, input ready);
  modport sink (input valid, is_data, bus_byte, last, output ready);
endinterface

// ===== sv/lcdn_front.sv =====
module lcdn_front import lcdn_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  lcdn_req_if.sink req_i,
  input  qstat_t qstat_i,
  output logic   push_o,
  output desc_t  desc_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e state_q, state_d;
  desc_t   desc_q, desc_new;
  logic [ValueWidth-1:0]  bin_q, mag;
  logic [3:0]             step_q, step_d;
  logic [DigitsWidth-1:0] adj;
  logic [4:0]             count_sat;
  logic                   accept, cmd_ok, has_write, need_conv;

  assign req_i.ready = (state_q == F_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    count_sat = (req_i.digit_count > 5'(MAX_DIGITS)) ? 5'(MAX_DIGITS) : req_i.digit_count;
    mag = (req_i.command == CMD_SDEC && req_i.value[ValueWidth-1])
          ? (ValueWidth'(0) - req_i.value) : req_i.value;

    desc_new.has_cursor  = (req_i.line == LINE_ONE) || (req_i.line == LINE_TWO);
    desc_new.cursor_byte = (req_i.line == LINE_TWO)
                           ? (SET_CURSOR | ({3'b000, req_i.column} + LINE_TWO_BASE - 8'd1))
                           : (SET_CURSOR | ({3'b000, req_i.column} - 8'd1));
    desc_new.has_lead  = 1'b0;
    desc_new.lead_byte = req_i.character;
    desc_new.count     = '0;
    desc_new.radix     = RADIX_DEC;
    cmd_ok             = 1'b1;
    need_conv          = 1'b0;

    unique case (req_i.command)
      CMD_CHAR: begin
        desc_new.has_lead = 1'b1;
      end
      CMD_UDEC: begin
        desc_new.count = count_sat;
        need_conv      = (count_sat != '0);
      end
      CMD_SDEC: begin
        desc_new.has_lead  = 1'b1;
        desc_new.lead_byte = req_i.value[ValueWidth-1] ? CHAR_MINUS : CHAR_PLUS;
        desc_new.count     = count_sat;
        need_conv          = (count_sat != '0);
      end
      CMD_HEX: begin
        desc_new.count = count_sat;
        desc_new.radix = RADIX_HEX;
      end
      CMD_BIN: begin
        desc_new.count = count_sat;
        desc_new.radix = RADIX_BIN;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase

    desc_new.digits = need_conv ? '0 : {{(DigitsWidth-ValueWidth){1'b0}}, mag};
    has_write = desc_new.has_cursor || desc_new.has_lead || (desc_new.count != '0);
  end

  // add-3 correction of each bcd digit before the shift
  always_comb begin
    for (int i = 0; i < int'(BcdDigits); i++) begin
      adj[4*i +: 4] = (desc_q.digits[4*i +: 4] >= 4'd5)
                      ? desc_q.digits[4*i +: 4] + 4'd3 : desc_q.digits[4*i +: 4];
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept && cmd_ok && has_write) begin
          state_d = need_conv ? F_CONV : F_PUSH;
          step_d  = '0;
        end
      end
      F_CONV: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'(ValueWidth - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!qstat_i.full) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= desc_new;
      bin_q  <= mag;
    end else if (state_q == F_CONV) begin
      desc_q.digits <= {adj[DigitsWidth-2:0], bin_q[ValueWidth-1]};
      bin_q         <= {bin_q[ValueWidth-2:0], 1'b0};
    end
  end

  assign push_o = (state_q == F_PUSH) && !qstat_i.full;
  assign desc_o = desc_q;

  a_conv_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_CONV |-> desc_q.radix == RADIX_DEC)
    else $error("conversion running on a non-decimal request");

endmodule

// ===== sv/lcdn_queue.sv =====
module lcdn_queue import lcdn_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  desc_t  desc_i,
  input  logic   pop_i,
  output desc_t  desc_o,
  output qstat_t stat_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  desc_t mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign stat_o.full  = (cnt_q == CntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign desc_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from an empty queue");

endmodule

// ===== sv/lcdn_back.sv =====
module lcdn_back import lcdn_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  desc_t  desc_i,
  input  qstat_t qstat_i,
  output logic   pop_o,
  lcdn_wr_if.source wr_o
);

  typedef enum logic [3:0] {
    B_IDLE   = 4'b0001,
    B_CURSOR = 4'b0010,
    B_LEAD   = 4'b0100,
    B_DIGIT  = 4'b1000
  } bstate_e;

  bstate_e state_q, state_d, phase;
  desc_t   cur_q, src;
  logic [4:0] pos_q, pos, pos_d;
  logic [3:0] p;
  logic       slot_free, active;
  logic       ovalid_q, odata_q, olast_q;
  logic [7:0] obyte_q;
  logic       e_data, e_last;
  logic [7:0] e_byte;

  function automatic bstate_e first_phase(input desc_t d);
    bstate_e s;
    if (d.has_cursor) begin
      s = B_CURSOR;
    end else if (d.has_lead) begin
      s = B_LEAD;
    end else begin
      s = B_DIGIT;
    end
    return s;
  endfunction

  function automatic logic [3:0] pick(input radix_e r, input logic [DigitsWidth-1:0] d,
                                      input logic [3:0] idx);
    logic [ValueWidth-1:0] v;
    logic [3:0]            n;
    v = d[ValueWidth-1:0];
    n = '0;
    case (r)
      RADIX_DEC: if (idx < 4'(BcdDigits)) n = d[{idx[2:0], 2'b00} +: 4];
      RADIX_HEX: if (idx < 4'(HexDigits)) n = v[{idx[1:0], 2'b00} +: 4];
      RADIX_BIN: n = {3'b000, v[idx]};
      default:   n = '0;
    endcase
    return n;
  endfunction

  assign slot_free = !ovalid_q || wr_o.ready;
  assign active    = (state_q != B_IDLE) || !qstat_i.empty;
  assign pop_o     = (state_q == B_IDLE) && !qstat_i.empty && slot_free;

  always_comb begin
    src   = (state_q == B_IDLE) ? desc_i : cur_q;
    pos   = (state_q == B_IDLE) ? desc_i.count : pos_q;
    phase = (state_q == B_IDLE) ? first_phase(desc_i) : state_q;
    p     = 4'(pos - 5'd1);

    state_d = state_q;
    pos_d   = pos_q;
    e_data  = 1'b1;
    e_byte  = src.lead_byte;
    e_last  = 1'b0;

    if (active && slot_free) begin
      pos_d = pos;
      unique case (phase)
        B_CURSOR: begin
          e_data  = 1'b0;
          e_byte  = src.cursor_byte;
          e_last  = !src.has_lead && (src.count == '0);
          state_d = src.has_lead ? B_LEAD : ((src.count != '0) ? B_DIGIT : B_IDLE);
        end
        B_LEAD: begin
          e_last  = (src.count == '0);
          state_d = (src.count != '0) ? B_DIGIT : B_IDLE;
        end
        B_DIGIT: begin
          e_byte  = digit_char(pick(src.radix, src.digits, p));
          e_last  = (pos == 5'd1);
          pos_d   = pos - 5'd1;
          state_d = (pos == 5'd1) ? B_IDLE : B_DIGIT;
        end
        default: begin
          state_d = B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      pos_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      if (slot_free) begin
        ovalid_q <= active;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= desc_i;
    end
    if (active && slot_free) begin
      odata_q <= e_data;
      obyte_q <= e_byte;
      olast_q <= e_last;
    end
  end

  assign wr_o.valid    = ovalid_q;
  assign wr_o.is_data  = odata_q;
  assign wr_o.bus_byte = obyte_q;
  assign wr_o.last     = olast_q;

  a_digits_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIGIT |-> pos_q != '0)
    else $error("digit phase with no digits left");

endmodule

// ===== sv/lcd_number_to_char_writes_unit.sv =====
// character lcd number display write sequencer
// req_i: valid/ready request channel carrying command, line, column,
//   character, value and digit_count; a transfer happens when both are high
// wr_o: valid/ready channel of lcd bus writes (is_data, bus_byte, last),
//   one transfer per bus write, last marks the final write of a request
// a request gives a set-cursor command on lines 1 and 2, then one character
//   or a sign and/or digit_count digits, most significant first
// the front takes a request only once the last is pushed to the queue:
//   character, hex, binary and zero-digit decimal skip conversion, and
//   decimal with digits runs shift-and-add-3 binary to bcd, one bit
//   per cycle over the 16-bit value; a request with no write is dropped
// a two-entry queue parts the front from the back, which emits one write
//   per cycle while the receiver is ready, from a registered output;
//   up to 18 writes per request; the first passes the front register, the
//   queue and the output register, after conversion for decimal with digits
// a stalled receiver holds the output register, the back, then the queue,
//   and finally the front deasserts ready
// reset empties the queue and drops any write in flight
module lcd_number_to_char_writes_unit import lcdn_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  lcdn_req_if.sink   req_i,
  lcdn_wr_if.source  wr_o
);

  desc_t  push_desc, head_desc;
  qstat_t qstat;
  logic   push, pop;

  lcdn_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .qstat_i(qstat),
    .push_o (push),
    .desc_o (push_desc)
  );

  lcdn_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .desc_i(push_desc),
    .pop_i (pop),
    .desc_o(head_desc),
    .stat_o(qstat)
  );

  lcdn_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .desc_i (head_desc),
    .qstat_i(qstat),
    .pop_o  (pop),
    .wr_o   (wr_o)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import lcdn_pkg::*;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  line;
    logic [4:0]  column;
    logic [7:0]  character;
    logic [15:0] value;
    logic [4:0]  digit_count;
  } lcd_req_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } lcd_write_t;

  class bus_write_scoreboard;
    lcd_write_t pending_writes[$];
    int errors;
    int requests;
    int silent_requests;
    int writes_checked;

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    // expected lcd bus writes for one accepted request
    function void note_request(lcd_req_t r);
      lcd_write_t run[$];
      lcd_write_t w;
      logic [7:0] col8;
      int unsigned mag;
      int unsigned radix;
      int unsigned n;
      int unsigned d;
      int unsigned digs[16];
      requests++;
      if (r.command > CMD_BIN) begin
        silent_requests++;
        return;
      end
      col8 = {3'b000, r.column} - 8'd1;
      if (r.line == LINE_ONE) begin
        run.push_back('{1'b0, SET_CURSOR | col8, 1'b0});
      end else if (r.line == LINE_TWO) begin
        run.push_back('{1'b0, SET_CURSOR | (col8 + LINE_TWO_BASE), 1'b0});
      end
      if (r.command == CMD_CHAR) begin
        run.push_back('{1'b1, r.character, 1'b0});
      end else begin
        n = (r.digit_count > MaxDigitsDef) ? MaxDigitsDef : r.digit_count;
        mag = r.value;
        radix = 10;
        if (r.command == CMD_SDEC) begin
          if (r.value[15]) begin
            run.push_back('{1'b1, CHAR_MINUS, 1'b0});
            mag = 32'h10000 - r.value;
          end else begin
            run.push_back('{1'b1, CHAR_PLUS, 1'b0});
          end
        end else if (r.command == CMD_HEX) begin
          radix = 16;
        end else if (r.command == CMD_BIN) begin
          radix = 2;
        end
        for (int i = 0; i < n; i++) begin
          digs[i] = mag % radix;
          mag = mag / radix;
        end
        for (int i = n; i > 0; i--) begin
          d = digs[i-1];
          w.is_data = 1'b1;
          w.bus_byte = (d < 10) ? CHAR_ZERO + 8'(d) : CHAR_A + 8'(d - 10);
          w.last = 1'b0;
          run.push_back(w);
        end
      end
      if (run.size() == 0) begin
        silent_requests++;
        return;
      end
      run[run.size()-1].last = 1'b1;
      foreach (run[i]) pending_writes.push_back(run[i]);
    endfunction

    task check_write(lcd_write_t got);
      lcd_write_t want;
      writes_checked++;
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("write %0b/%02h/%0b with none pending",
                                  got.is_data, got.bus_byte, got.last));
        return;
      end
      want = pending_writes.pop_front();
      if (got.is_data !== want.is_data)
        report_mismatch($sformatf("write %0d is_data got %0b want %0b",
                                  writes_checked, got.is_data, want.is_data));
      if (got.bus_byte !== want.bus_byte)
        report_mismatch($sformatf("write %0d bus_byte got %02h want %02h",
                                  writes_checked, got.bus_byte, want.bus_byte));
      if (got.last !== want.last)
        report_mismatch($sformatf("write %0d last got %0b want %0b",
                                  writes_checked, got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_ni;
  bit   no_idle;

  lcdn_req_if req();
  lcdn_wr_if  wr();

  bus_write_scoreboard board = new();

  always #4 clk = ~clk;

  lcd_number_to_char_writes_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .req_i  (req),
    .wr_o   (wr)
  );

  task automatic send_request(lcd_req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.command     <= r.command;
    req.line        <= r.line;
    req.column      <= r.column;
    req.character   <= r.character;
    req.value       <= r.value;
    req.digit_count <= r.digit_count;
    do @(posedge clk); while (!req.ready);
    board.note_request(r);
  endtask

  // write receiver with random stalls
  initial begin
    int stall;
    wr.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        wr.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      wr.ready <= 1'b1;
      do @(posedge clk); while (wr.valid !== 1'b1);
      board.check_write('{wr.is_data, wr.bus_byte, wr.last});
    end
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    lcd_req_t r;
    lcd_req_t directed[$];
    int shown;
    rst_ni          <= 1'b0;
    no_idle         = 1'b0;
    req.valid       <= 1'b0;
    req.command     <= CMD_CHAR;
    req.line        <= '0;
    req.column      <= '0;
    req.character   <= '0;
    req.value       <= '0;
    req.digit_count <= '0;
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    directed = '{
      '{CMD_CHAR, 2'd1, 5'd1,  8'h00, 16'h0000, 5'd0},
      '{CMD_CHAR, 2'd2, 5'd16, 8'hFF, 16'hFFFF, 5'd31},
      '{CMD_CHAR, 2'd0, 5'd5,  8'h41, 16'h1234, 5'd4},
      '{CMD_CHAR, 2'd3, 5'd9,  8'h7E, 16'h0000, 5'd1},
      '{CMD_UDEC, 2'd1, 5'd1,  8'h00, 16'h0000, 5'd5},
      '{CMD_UDEC, 2'd2, 5'd16, 8'h00, 16'hFFFF, 5'd16},
      '{CMD_UDEC, 2'd0, 5'd3,  8'h00, 16'd123,  5'd0},
      '{CMD_UDEC, 2'd1, 5'd3,  8'h00, 16'd123,  5'd0},
      '{CMD_UDEC, 2'd3, 5'd2,  8'h00, 16'd12345, 5'd3},
      '{CMD_SDEC, 2'd1, 5'd4,  8'h00, 16'h8000, 5'd5},
      '{CMD_SDEC, 2'd2, 5'd4,  8'h00, 16'h7FFF, 5'd5},
      '{CMD_SDEC, 2'd0, 5'd1,  8'h00, 16'h0000, 5'd1},
      '{CMD_SDEC, 2'd1, 5'd7,  8'h00, 16'hFFFF, 5'd3},
      '{CMD_SDEC, 2'd3, 5'd7,  8'h00, 16'hFFFF, 5'd0},
      '{CMD_HEX,  2'd1, 5'd8,  8'h00, 16'hABCD, 5'd4},
      '{CMD_HEX,  2'd2, 5'd1,  8'h00, 16'hFFFF, 5'd16},
      '{CMD_BIN,  2'd1, 5'd1,  8'h00, 16'h8001, 5'd16},
      '{CMD_BIN,  2'd0, 5'd1,  8'h00, 16'h5555, 5'd31},
      '{3'd5,     2'd1, 5'd1,  8'h00, 16'h0001, 5'd4},
      '{3'd6,     2'd2, 5'd2,  8'h00, 16'h0002, 5'd4},
      '{3'd7,     2'd0, 5'd3,  8'h00, 16'h0003, 5'd4},
      '{CMD_CHAR, 2'd1, 5'd0,  8'h30, 16'h0000, 5'd0},
      '{CMD_HEX,  2'd2, 5'd0,  8'h00, 16'h00F0, 5'd2},
      '{CMD_CHAR, 2'd2, 5'd31, 8'h5A, 16'h0000, 5'd0}
    };
    foreach (directed[i]) send_request(directed[i]);

    shown = 0;
    while (shown < 320) begin
      if ($urandom_range(0, 31) == 0) no_idle = !no_idle;
      r.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
      r.line = 2'($urandom_range(0, 3));
      r.column = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(1, 16));
      r.character = 8'($urandom);
      case ($urandom_range(0, 7))
        0: r.value = 16'h0000;
        1: r.value = 16'hFFFF;
        2: r.value = 16'h8000;
        3: r.value = 16'h7FFF;
        default: r.value = 16'($urandom);
      endcase
      r.digit_count = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                                  : 5'($urandom_range(0, 16));
      send_request(r);
      if (r.command <= CMD_BIN) shown++;
    end
    req.valid <= 1'b0;

    while (board.pending_writes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d requests (%0d with no bus write), %0d lcd writes checked",
             board.requests, board.silent_requests, board.writes_checked);
    $display("modes: character, unsigned/signed decimal, hex, binary, unknown commands");
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/lcdn_pkg.sv
sv/lcdn_if.sv
sv/lcdn_front.sv
sv/lcdn_queue.sv
sv/lcdn_back.sv
sv/lcd_number_to_char_writes_unit.sv
tb/tb.sv
